// ===== hdl/bpa_pkg.sv =====
package bpa_pkg;

    localparam int MAX_PAGES     = 4096;
    localparam int PAGE_SHIFT    = 12;

    localparam int ADDR_W        = 48;
    localparam int LIMIT_W       = 13;
    localparam int COUNT_FIELD_W = 13;
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 48;

    localparam int WORD_BITS     = 64;
    localparam int BIT_W         = 6;
    localparam int BITMAP_WORDS  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_W        = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int PIDX_W        = WORD_W + BIT_W;
    localparam int PTR_W         = WORD_W + 1;
    localparam int SB_W          = PTR_W + BIT_W;
    localparam int LIM_W         = $clog2(MAX_PAGES + 1);
    localparam int CMP_W         = (LIM_W > LIMIT_W) ? LIM_W : LIMIT_W;
    localparam int PAGE_NUM_W    = ADDR_W - PAGE_SHIFT;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_LIMIT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_RELEASE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACQ_SCAN,
        ST_ACQ_COMMIT,
        ST_REL_CALC,
        ST_REL_READ,
        ST_REL_CHECK,
        ST_RESP
    } bpa_state_t;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] page_address;
    } bpa_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0]        granted_address;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_FIELD_W-1:0] pages_in_use;
    } bpa_out_t;

    typedef struct packed {
        logic start_acq;
        logic start_rel;
        logic scan;
        logic acq_fail;
        logic acq_commit;
        logic rel_calc;
        logic rel_read;
        logic rel_check;
        logic load_out;
    } bpa_cmd_t;

    typedef struct packed {
        logic found;
        logic exhausted;
        logic out_free;
    } bpa_stat_t;

endpackage

// ===== hdl/bitmap_page_allocator_core.sv =====
// Acquire: the scan reads n bitmap words, one per cycle from the single bitmap read port,
// where n is at most 64, also for a full store, then commits a found page and loads the result.
// A zero page limit reads no word and answers with no free page.
// Release: the result is loaded after three steps (address check, word read, update).
// One item is in flight at a time; the next is accepted in the cycle after the result is loaded,
// and a full output register holds the block until the waiting result is taken.
// Reset is synchronous and active low; it clears the per-word valid flags so every page is free
// at once, with no clearing pass, and restores the page limit and base address.
module bitmap_page_allocator_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  bpa_pkg::bpa_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output bpa_pkg::bpa_out_t              m_data
);
    import bpa_pkg::*;

    bpa_cmd_t  cmd;
    bpa_stat_t stat;

    bpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_data.cmd),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bpa_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

// ===== hdl/bpa_ctrl.sv =====
module bpa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_cmd,
    output logic              s_ready,
    input  bpa_pkg::bpa_stat_t stat,
    output bpa_pkg::bpa_cmd_t  cmd
);
    import bpa_pkg::*;

    bpa_state_t state_reg;
    bpa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_cmd == CMD_RELEASE) ? ST_REL_CALC : ST_ACQ_SCAN;
                end
            end
            ST_ACQ_SCAN: begin
                if (stat.found) begin
                    state_next = ST_ACQ_COMMIT;
                end else if (stat.exhausted) begin
                    state_next = ST_RESP;
                end
            end
            ST_ACQ_COMMIT: state_next = ST_RESP;
            ST_REL_CALC:   state_next = ST_REL_READ;
            ST_REL_READ:   state_next = ST_REL_CHECK;
            ST_REL_CHECK:  state_next = ST_RESP;
            ST_RESP: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = (state_reg == ST_IDLE);
        cmd            = '0;
        cmd.start_acq  = (state_reg == ST_IDLE) && s_valid && (s_cmd == CMD_ACQUIRE);
        cmd.start_rel  = (state_reg == ST_IDLE) && s_valid && (s_cmd == CMD_RELEASE);
        cmd.scan       = (state_reg == ST_ACQ_SCAN);
        cmd.acq_fail   = (state_reg == ST_ACQ_SCAN) && stat.exhausted && !stat.found;
        cmd.acq_commit = (state_reg == ST_ACQ_COMMIT);
        cmd.rel_calc   = (state_reg == ST_REL_CALC);
        cmd.rel_read   = (state_reg == ST_REL_READ);
        cmd.rel_check  = (state_reg == ST_REL_CHECK);
        cmd.load_out   = (state_reg == ST_RESP) && stat.out_free;
    end

`ifndef ASSERT_OFF
    a_resp_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP) && !stat.out_free |=> (state_reg == ST_RESP))
        else $error("Result state left while the output register was full.");
`endif

endmodule

// ===== hdl/bpa_datapath.sv =====
module bpa_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  bpa_pkg::bpa_in_t                 in_data,
    input  bpa_pkg::bpa_cmd_t                cmd,
    output bpa_pkg::bpa_stat_t               stat,
    input  logic                             m_ready,
    output logic                             m_valid,
    output bpa_pkg::bpa_out_t                m_data
);
    import bpa_pkg::*;

    logic [LIMIT_W-1:0]       limit_reg;
    logic [ADDR_W-1:0]        base_reg;
    logic [LIM_W-1:0]         lim_reg;
    logic [LIM_W-1:0]         count_reg;

    logic [WORD_BITS-1:0]     bitmap_mem [BITMAP_WORDS];
    logic [BITMAP_WORDS-1:0]  word_valid_reg;
    logic [WORD_BITS-1:0]     rd_data_reg;
    logic                     rd_valid_reg;

    logic [PTR_W-1:0]         scan_ptr_reg;
    logic [WORD_W-1:0]        chk_word_reg;
    logic                     chk_live_reg;
    logic [WORD_W-1:0]        hit_word_reg;
    logic [BIT_W-1:0]         hit_bit_reg;
    logic [WORD_BITS-1:0]     hit_data_reg;

    logic [ADDR_W-1:0]        rel_addr_reg;
    logic [PIDX_W-1:0]        rel_idx_reg;
    logic                     rel_ok_reg;

    logic [ADDR_W-1:0]        res_addr_reg;
    logic [STATUS_W-1:0]      res_status_reg;
    logic                     m_valid_reg;
    bpa_out_t                 m_data_reg;

    logic [LIM_W-1:0]         lim_eff;
    logic [SB_W-1:0]          scan_base;
    logic                     issue_ok;
    logic [WORD_BITS-1:0]     cur_word;
    logic [SB_W-1:0]          rem;
    logic [WORD_BITS-1:0]     live_mask;
    logic [WORD_BITS-1:0]     free_bits;
    logic [WORD_BITS-1:0]     low_bit;
    logic [BIT_W-1:0]         low_idx;
    logic                     found;
    logic [ADDR_W:0]          rel_diff;
    logic [PAGE_NUM_W-1:0]    rel_page;
    logic                     rel_hit;
    logic [ADDR_W-1:0]        granted;
    logic                     rd_en;
    logic [WORD_W-1:0]        rd_addr;
    logic                     wr_en;
    logic [WORD_W-1:0]        wr_addr;
    logic [WORD_BITS-1:0]     wr_data;

    always_comb begin
        lim_eff = (CMP_W'(limit_reg) > CMP_W'(MAX_PAGES)) ? LIM_W'(MAX_PAGES)
                                                          : LIM_W'(limit_reg);
        scan_base = {scan_ptr_reg, BIT_W'(0)};
        issue_ok  = scan_base < SB_W'(lim_reg);

        cur_word  = rd_valid_reg ? rd_data_reg : '0;
        rem       = SB_W'(lim_reg) - {1'b0, chk_word_reg, BIT_W'(0)};
        live_mask = (rem >= SB_W'(WORD_BITS)) ? '1
                                              : ((WORD_BITS'(1) << rem[BIT_W-1:0])
                                                 - WORD_BITS'(1));
        free_bits = ~cur_word & live_mask;
        low_bit   = free_bits & (~free_bits + WORD_BITS'(1));
        low_idx   = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            low_idx = low_idx | (low_bit[b] ? BIT_W'(b) : BIT_W'(0));
        end
        found = chk_live_reg && (|free_bits);

        rel_diff = {1'b0, rel_addr_reg} - {1'b0, base_reg};
        rel_page = rel_diff[ADDR_W-1:PAGE_SHIFT];
        rel_hit  = rel_ok_reg && cur_word[rel_idx_reg[BIT_W-1:0]];

        granted = base_reg + (ADDR_W'({hit_word_reg, hit_bit_reg}) << PAGE_SHIFT);

        rd_en   = (cmd.scan && issue_ok) || cmd.rel_read;
        rd_addr = cmd.scan ? scan_ptr_reg[WORD_W-1:0] : rel_idx_reg[PIDX_W-1:BIT_W];

        wr_en   = cmd.acq_commit || (cmd.rel_check && rel_hit);
        wr_addr = cmd.acq_commit ? hit_word_reg : rel_idx_reg[PIDX_W-1:BIT_W];
        wr_data = cmd.acq_commit ? hit_data_reg
                                 : (cur_word & ~(WORD_BITS'(1) << rel_idx_reg[BIT_W-1:0]));

        stat.found     = found;
        stat.exhausted = !issue_ok && !chk_live_reg;
        stat.out_free  = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bitmap_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= bitmap_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg      <= LIMIT_W'(MAX_PAGES);
            base_reg       <= '0;
            count_reg      <= '0;
            word_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            chk_live_reg   <= 1'b0;
            scan_ptr_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_PAGE_LIMIT:   limit_reg <= cfg_wdata[LIMIT_W-1:0];
                    REG_BASE_ADDRESS: base_reg  <= cfg_wdata[ADDR_W-1:0];
                    default: ;
                endcase
            end
            if (rd_en) begin
                rd_valid_reg <= word_valid_reg[rd_addr];
            end
            if (wr_en) begin
                word_valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.start_acq) begin
                scan_ptr_reg <= '0;
                chk_live_reg <= 1'b0;
            end else if (cmd.scan) begin
                chk_live_reg <= issue_ok;
                if (issue_ok) begin
                    scan_ptr_reg <= scan_ptr_reg + PTR_W'(1);
                end
            end
            if (cmd.acq_commit) begin
                count_reg <= count_reg + LIM_W'(1);
            end else if (cmd.rel_check && rel_hit) begin
                count_reg <= count_reg - LIM_W'(1);
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_acq) begin
            lim_reg <= lim_eff;
        end
        if (cmd.scan) begin
            chk_word_reg <= scan_ptr_reg[WORD_W-1:0];
        end
        if (cmd.scan && found) begin
            hit_word_reg <= chk_word_reg;
            hit_bit_reg  <= low_idx;
            hit_data_reg <= cur_word | low_bit;
        end
        if (cmd.start_rel) begin
            rel_addr_reg <= in_data.page_address;
        end
        if (cmd.rel_calc) begin
            rel_ok_reg  <= !rel_diff[ADDR_W] && (rel_page < PAGE_NUM_W'(MAX_PAGES));
            rel_idx_reg <= rel_page[PIDX_W-1:0];
        end
        if (cmd.acq_commit) begin
            res_addr_reg   <= granted;
            res_status_reg <= STATUS_OK;
        end else if (cmd.acq_fail) begin
            res_addr_reg   <= '0;
            res_status_reg <= STATUS_NO_FREE;
        end else if (cmd.rel_check) begin
            res_addr_reg   <= '0;
            res_status_reg <= rel_hit ? STATUS_OK : STATUS_BAD_RELEASE;
        end
        if (cmd.load_out) begin
            m_data_reg.granted_address <= res_addr_reg;
            m_data_reg.status          <= res_status_reg;
            m_data_reg.pages_in_use    <= COUNT_FIELD_W'(count_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_acquire_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.acq_commit |=> (count_reg == $past(count_reg) + LIM_W'(1)))
        else $error("Granted page was not added to the count.");
    a_release_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rel_check && rel_hit |=> (count_reg == $past(count_reg) - LIM_W'(1)))
        else $error("Released page was not removed from the count.");
    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (cmd.acq_commit || cmd.rel_check))
        else $error("Bitmap written outside a commit or release check.");
    a_result_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid_reg
                         && (m_data_reg.pages_in_use == COUNT_FIELD_W'($past(count_reg))))
        else $error("Result item carries a stale page count.");
`endif

endmodule
